@@ rtl/pwk_pkg.sv @@
package pwk_pkg;

	localparam int WHEELS = 6;
	localparam int POS_W  = 5;
	localparam int CAM_W  = 25;
	localparam int IDX_W  = 3;
	localparam int DIG_W  = 5;

	localparam int WHEEL_SIZE [WHEELS] = '{25, 25, 23, 23, 24, 24};

	localparam logic [CAM_W-1:0] CAM_MASK [WHEELS] = '{
		25'h1ff_ffff, 25'h1ff_ffff, 25'h07f_ffff,
		25'h07f_ffff, 25'h0ff_ffff, 25'h0ff_ffff
	};

	localparam logic [IDX_W-1:0] REG_CAMS_ONE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_CAMS_TWO   = 3'd1;
	localparam logic [IDX_W-1:0] REG_CAMS_THREE = 3'd2;
	localparam logic [IDX_W-1:0] REG_CAMS_FOUR  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CAMS_FIVE  = 3'd4;
	localparam logic [IDX_W-1:0] REG_CAMS_SIX   = 3'd5;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_CHECK = 1'b1;

	// what a wheel hands to its right-hand neighbor
	typedef struct packed {
		logic cam5_pre;   // cam at -5, position before the optional first step
		logic cam5_mid;   // cam at -5, position after the optional first step
		logic cam8_mid;   // cam at +8, position after the optional first step
	} cell_link_t;

	typedef struct packed {
		logic               load;
		logic               check;
		logic               pre_step;
		logic [POS_W-1:0]   load_pos;
	} cell_ctrl_t;

endpackage

@@ rtl/pinwheel_keystream_checker.sv @@
// Six-wheel pinwheel keystream checker. Each wheel is a cell holding its
// position; every cycle it hands its cam bits to the wheel on its right, and
// both wheel steps of a check are resolved inside the cells in the cycle the
// item is transferred. One item per clock is sustained while m_axis_tready
// is high; a two-entry output buffer (output register, skid entry) keeps the
// input open while m_axis_tready is low until the skid fills. The user writes
// cam patterns on the cfg port only while no item is in flight (not enforced).
module pinwheel_keystream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_one, start_two, start_three, start_four, start_five, start_six,
	// expected_digit, 5 bits each from bit 0; bits 39:35 zero
	input  logic [39:0] s_axis_tdata,
	// mode
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// generated_digit[4:0], digit_matches[5], all_consistent[6], bad_load[7]
	output logic [7:0]  m_axis_tdata
);
	import pwk_pkg::*;

	logic [CAM_W-1:0]  cams_q [WHEELS];
	logic              consistent_q;
	logic              out_v_q;
	logic [7:0]        out_q;
	logic              skid_v_q;
	logic [7:0]        skid_q;

	logic              take;
	logic              is_check;
	logic              bad;
	logic              good_load;
	logic [DIG_W-1:0]  digit;
	logic              match;
	logic              cons_next;
	logic [7:0]        result;
	logic              inv;
	cell_link_t        links [WHEELS];
	cell_ctrl_t        ctrl  [WHEELS];

	assign s_axis_tready = !skid_v_q;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign is_check      = s_axis_tuser == MODE_CHECK;

	always_comb begin
		bad = 1'b0;
		for (int w = 0; w < WHEELS; w++) begin
			if (s_axis_tdata[w*POS_W +: POS_W] >= POS_W'(WHEEL_SIZE[w])) begin
				bad = 1'b1;
			end
		end
	end

	assign good_load = take && !is_check && !bad;

	for (genvar g = 0; g < WHEELS; g++) begin : g_wheel
		localparam int S = WHEEL_SIZE[g];
		assign ctrl[g].load     = good_load;
		assign ctrl[g].check    = take && is_check;
		assign ctrl[g].pre_step = links[WHEELS-1].cam5_pre;
		assign ctrl[g].load_pos = s_axis_tdata[g*POS_W +: POS_W];

		pwk_wheel_cell #(
			.SIZE (S)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cams   (cams_q[g][S-1:0]),
			.ctrl   (ctrl[g]),
			.left   ((g == 0) ? cell_link_t'('0) : links[(g == 0) ? 0 : g-1]),
			.link   (links[g])
		);
	end

	always_comb begin
		inv   = links[WHEELS-1].cam8_mid;
		digit = DIG_W'(inv ^ links[0].cam8_mid)
			+ (DIG_W'(inv ^ links[1].cam8_mid) << 1)
			+ (DIG_W'(inv ^ links[2].cam8_mid) << 2)
			+ (DIG_W'(inv ^ links[3].cam8_mid) << 3)
			+ ((inv ^ links[4].cam8_mid) ? DIG_W'(10) : DIG_W'(0));
		match = digit == s_axis_tdata[WHEELS*POS_W +: DIG_W];
		if (is_check) begin
			cons_next = consistent_q & match;
			result    = {1'b0, cons_next, match, digit};
		end else begin
			cons_next = bad ? consistent_q : 1'b1;
			result    = {bad, cons_next, 1'b0, DIG_W'(0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WHEELS; w++) begin
				cams_q[w] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAMS_ONE:   cams_q[0] <= cfg_data & CAM_MASK[0];
				REG_CAMS_TWO:   cams_q[1] <= cfg_data & CAM_MASK[1];
				REG_CAMS_THREE: cams_q[2] <= cfg_data & CAM_MASK[2];
				REG_CAMS_FOUR:  cams_q[3] <= cfg_data & CAM_MASK[3];
				REG_CAMS_FIVE:  cams_q[4] <= cfg_data & CAM_MASK[4];
				REG_CAMS_SIX:   cams_q[5] <= cfg_data & CAM_MASK[5];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consistent_q <= 1'b1;
		end else if (take) begin
			consistent_q <= cons_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !m_axis_tready) begin
			if (take) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !m_axis_tready) begin
			if (take) begin
				skid_q <= result;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else if (take) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with output register empty");

	a_load_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		good_load |=> consistent_q)
		else $error("good load did not set consistency flag");

	a_bad_load_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q[7] |-> out_q[5:0] == 6'd0)
		else $error("bad load result carries digit or match");

	a_mismatch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_check && !match |=> !consistent_q)
		else $error("mismatch left consistency flag set");

endmodule

@@ rtl/pwk_wheel_cell.sv @@
module pwk_wheel_cell #(
	parameter int SIZE = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SIZE-1:0]        cams,
	input  pwk_pkg::cell_ctrl_t    ctrl,
	input  pwk_pkg::cell_link_t    left,
	output pwk_pkg::cell_link_t    link
);
	import pwk_pkg::*;

	localparam logic [POS_W:0] SIZE_X = (POS_W+1)'(SIZE);
	localparam logic [POS_W:0] OFF_P5 = (POS_W+1)'(SIZE - 5);
	localparam logic [POS_W:0] OFF_M8 = (POS_W+1)'(8 % SIZE);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_mid;
	logic [POS_W-1:0] pos_end;
	logic [POS_W-1:0] idx_p5_pre;
	logic [POS_W-1:0] idx_p5_mid;
	logic [POS_W-1:0] idx_m8_mid;

	function automatic logic [POS_W-1:0] wrap(input logic [POS_W:0] v);
		logic [POS_W:0] r;
		r = (v >= SIZE_X) ? v - SIZE_X : v;
		return r[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p, input logic extra);
		return wrap({1'b0, p} + (POS_W+1)'(1) + (POS_W+1)'(extra));
	endfunction

	always_comb begin
		idx_p5_pre = wrap({1'b0, pos_q} + OFF_P5);
		pos_mid    = ctrl.pre_step ? advance(pos_q, left.cam5_pre) : pos_q;
		idx_p5_mid = wrap({1'b0, pos_mid} + OFF_P5);
		idx_m8_mid = wrap({1'b0, pos_mid} + OFF_M8);
		pos_end    = advance(pos_mid, left.cam5_mid);
		link.cam5_pre = cams[idx_p5_pre];
		link.cam5_mid = cams[idx_p5_mid];
		link.cam8_mid = cams[idx_m8_mid];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctrl.load) begin
			pos_q <= ctrl.load_pos;
		end else if (ctrl.check) begin
			pos_q <= pos_end;
		end
	end

endmodule
